>>> rtl/sbs_pkg.sv
`timescale 1ns / 1ps
package sbs_pkg;

  localparam int unsigned COLUMNS  = 20;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned LEVEL_W  = 6;
  localparam int unsigned NUM_W    = SAMPLE_W + LEVEL_W;
  localparam int unsigned COL_W    = 5;
  localparam int unsigned CODE_W   = 8;
  localparam int unsigned CNT_W    = $clog2(COLUMNS);
  localparam int unsigned HIST_W   = (COLUMNS > 2) ? $clog2(COLUMNS - 1) : 1;
  localparam int unsigned QDEPTH   = 2;
  localparam int unsigned QPTR_W   = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W   = $clog2(QDEPTH + 1);

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = LEVEL_W'(32);
  localparam logic [CODE_W-1:0]  CODE_BLANK = 8'd254;
  localparam logic [CODE_W-1:0]  CODE_FULL  = 8'd255;

  localparam logic signed [SAMPLE_W-1:0] START_MIN_RST = 16'sd0;
  localparam logic signed [SAMPLE_W-1:0] START_MAX_RST = 16'sd5000;

  localparam logic REG_START_MIN = 1'b0;
  localparam logic REG_START_MAX = 1'b1;

  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_REINIT = 1'b1;

  typedef struct packed {
    logic                       req_type;
    logic signed [SAMPLE_W-1:0] sample;
  } sbs_in_t;

  typedef struct packed {
    logic [COL_W-1:0]  column;
    logic [CODE_W-1:0] row1_code;
    logic [CODE_W-1:0] row2_code;
    logic [CODE_W-1:0] row3_code;
    logic [CODE_W-1:0] row4_code;
    logic              last;
  } sbs_out_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_SCALE,
    F_DIV,
    F_PUSH
  } front_state_e;

  typedef enum logic {
    B_IDLE,
    B_EMIT
  } back_state_e;

  // cells[0] is the bottom line
  function automatic logic [3:0][CODE_W-1:0] bar_cells(input logic [LEVEL_W-1:0] level);
    logic [2:0]              filled;
    logic [CODE_W-1:0]       top;
    logic [3:0][CODE_W-1:0]  cells;
    filled = 3'(level >> 3);
    top    = (level[2:0] != 3'd0) ? CODE_W'(level[2:0]) : CODE_BLANK;
    for (int r = 0; r < 4; r++) begin
      if (3'(r) < filled) begin
        cells[r] = CODE_FULL;
      end else if (3'(r) == filled) begin
        cells[r] = top;
      end else begin
        cells[r] = CODE_BLANK;
      end
    end
    return cells;
  endfunction

endpackage

>>> rtl/scrolling_bar_scope.sv
`timescale 1ns / 1ps
// Scrolling bar graph for a four-line character display.
// Input queue side: push/full; in_data_i carries req_type and sample.
// A sample transaction widens the running min/max, scales to a level 0..32
// and yields COLUMNS result transactions: the live column (COLUMNS-1) first,
// then columns 0..COLUMNS-2 from history, last set on the final one.
// A reinit transaction reloads min/max from start_min/start_max, no results.
// Result queue side: empty/pop; out_data_o holds the oldest result.
// Config: cfg_we_i writes cfg_wdata_i to register cfg_idx_i (0 start_min,
// 1 start_max). Write only while no transaction is in flight; the block
// itself does not enforce this. Front steps per sample: accept, scale,
// 6-step divider, enqueue (held while the level queue is full).
// Throughput: one result per cycle while the receiver keeps the output slot
// free; a sample holds the back end for a level fetch, then one column per
// result. full stays high until a sample's level is queued, not after reinit.
// A two-entry level queue decouples divider and emitter; a stalled receiver
// holds the emitter, the queue fills and the front then keeps full high.
// Reset: marks load 0/5000, history clears to level 0, queues empty.
module scrolling_bar_scope import sbs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [SAMPLE_W-1:0] cfg_wdata_i,
  input  logic                push,
  output logic                full,
  input  sbs_in_t             in_data_i,
  output logic                empty,
  input  logic                pop,
  output sbs_out_t            out_data_o
);

  logic               q_push, q_full, q_pop, q_empty;
  logic [LEVEL_W-1:0] q_wlevel, q_rlevel;

  sbs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push        (push),
    .full        (full),
    .in_data_i   (in_data_i),
    .q_push_o    (q_push),
    .q_level_o   (q_wlevel),
    .q_full_i    (q_full)
  );

  sbs_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wlevel),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_rlevel),
    .empty_o (q_empty)
  );

  sbs_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .q_level_i  (q_rlevel),
    .q_pop_o    (q_pop),
    .empty      (empty),
    .pop        (pop),
    .out_data_o (out_data_o)
  );

endmodule

>>> rtl/sbs_front.sv
`timescale 1ns / 1ps
module sbs_front import sbs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [SAMPLE_W-1:0] cfg_wdata_i,
  input  logic                push,
  output logic                full,
  input  sbs_in_t             in_data_i,
  output logic                q_push_o,
  output logic [LEVEL_W-1:0]  q_level_o,
  input  logic                q_full_i
);

  front_state_e state_q, state_d;

  logic signed [SAMPLE_W-1:0] start_min_q, start_max_q;
  logic signed [SAMPLE_W-1:0] low_q, high_q;
  logic signed [SAMPLE_W-1:0] smp_q;
  logic [NUM_W-1:0]           rem_q;
  logic [SAMPLE_W-1:0]        dvs_q;
  logic [LEVEL_W-1:0]         quo_q;
  logic [2:0]                 step_q;
  logic                       zero_q;

  logic                       accept;
  logic [SAMPLE_W:0]          diff_w, span_w;
  logic [SAMPLE_W-1:0]        diff, span;
  logic [NUM_W-1:0]           num;
  logic [NUM_W-1:0]           trial;
  logic                       fits;
  logic [LEVEL_W-1:0]         level;

  assign accept = push && !full;

  // marks are ordered once widened, so both differences are non-negative
  assign diff_w = {smp_q[SAMPLE_W-1], smp_q} - {low_q[SAMPLE_W-1], low_q};
  assign span_w = {high_q[SAMPLE_W-1], high_q} - {low_q[SAMPLE_W-1], low_q};
  assign diff   = diff_w[SAMPLE_W-1:0];
  assign span   = span_w[SAMPLE_W-1:0];
  assign num    = {1'b0, diff, 5'b0} + {{LEVEL_W{1'b0}}, diff};

  assign trial = {{LEVEL_W{1'b0}}, dvs_q} << step_q;
  assign fits  = rem_q >= trial;

  assign level = zero_q ? '0 : ((quo_q > LEVEL_MAX) ? LEVEL_MAX : quo_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE: begin
        if (accept && in_data_i.req_type == REQ_SAMPLE) begin
          state_d = F_SCALE;
        end
      end
      F_SCALE: state_d = F_DIV;
      F_DIV: begin
        if (step_q == 3'd0) begin
          state_d = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!q_full_i) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_comb begin
    full      = 1'b1;
    q_push_o  = 1'b0;
    q_level_o = level;
    case (state_q)
      F_IDLE:  full = 1'b0;
      F_PUSH:  q_push_o = !q_full_i;
      default: full = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= F_IDLE;
      start_min_q <= START_MIN_RST;
      start_max_q <= START_MAX_RST;
      low_q       <= START_MIN_RST;
      high_q      <= START_MAX_RST;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_START_MIN: start_min_q <= cfg_wdata_i;
          REG_START_MAX: start_max_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (accept) begin
        if (in_data_i.req_type == REQ_REINIT) begin
          low_q  <= start_min_q;
          high_q <= start_max_q;
        end else begin
          if (in_data_i.sample < low_q) begin
            low_q <= in_data_i.sample;
          end
          if (in_data_i.sample > high_q) begin
            high_q <= in_data_i.sample;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      smp_q <= in_data_i.sample;
    end
    if (state_q == F_SCALE) begin
      rem_q  <= num;
      dvs_q  <= span;
      zero_q <= (span == '0);
      quo_q  <= '0;
      step_q <= 3'(LEVEL_W - 1);
    end else if (state_q == F_DIV) begin
      if (fits) begin
        rem_q         <= rem_q - trial;
        quo_q[step_q] <= 1'b1;
      end
      step_q <= step_q - 3'd1;
    end
  end

  a_marks_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == F_SCALE |-> (low_q <= smp_q) && (smp_q <= high_q))
    else $error("sample outside widened marks");

  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push_o |-> q_level_o <= LEVEL_MAX)
    else $error("level above full scale");

endmodule

>>> rtl/sbs_fifo.sv
`timescale 1ns / 1ps
module sbs_fifo import sbs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  logic [LEVEL_W-1:0] data_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic [LEVEL_W-1:0] data_o,
  output logic               empty_o
);

  logic [LEVEL_W-1:0] mem_q [QDEPTH];
  logic [QPTR_W-1:0]  wptr_q, rptr_q;
  logic [QCNT_W-1:0]  cnt_q;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("level queue overflow");

endmodule

>>> rtl/sbs_back.sv
`timescale 1ns / 1ps
module sbs_back import sbs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_empty_i,
  input  logic [LEVEL_W-1:0] q_level_i,
  output logic               q_pop_o,
  output logic               empty,
  input  logic               pop,
  output sbs_out_t           out_data_o
);

  back_state_e state_q, state_d;

  logic [LEVEL_W-1:0] lvl_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [LEVEL_W-1:0] hist_q [COLUMNS-1];
  sbs_out_t           out_q;
  logic               out_valid_q;

  logic                   slot_free;
  logic                   load;
  logic                   done;
  logic [HIST_W-1:0]      hidx;
  logic [LEVEL_W-1:0]     cur_level;
  logic [3:0][CODE_W-1:0] cells;
  sbs_out_t               bar;

  assign slot_free = !out_valid_q || pop;
  assign done      = (cnt_q == CNT_W'(COLUMNS - 1));
  assign hidx      = HIST_W'(cnt_q - CNT_W'(1));
  assign cur_level = (cnt_q == '0) ? lvl_q : hist_q[hidx];
  assign cells     = bar_cells(cur_level);

  always_comb begin
    bar.column    = (cnt_q == '0) ? COL_W'(COLUMNS - 1) : COL_W'(cnt_q - CNT_W'(1));
    bar.row1_code = cells[3];
    bar.row2_code = cells[2];
    bar.row3_code = cells[1];
    bar.row4_code = cells[0];
    bar.last      = done;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE: begin
        if (!q_empty_i) begin
          state_d = B_EMIT;
        end
      end
      B_EMIT: begin
        if (slot_free && done) begin
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_comb begin
    q_pop_o = 1'b0;
    load    = 1'b0;
    case (state_q)
      B_IDLE:  q_pop_o = !q_empty_i;
      B_EMIT:  load = slot_free;
      default: load = 1'b0;
    endcase
  end

  assign empty      = !out_valid_q;
  assign out_data_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
      for (int i = 0; i < COLUMNS - 1; i++) begin
        hist_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
      if (load && done) begin
        for (int i = 0; i < COLUMNS - 2; i++) begin
          hist_q[i] <= hist_q[i + 1];
        end
        hist_q[COLUMNS - 2] <= lvl_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      lvl_q <= q_level_i;
      cnt_q <= '0;
    end else if (load && !done) begin
      cnt_q <= cnt_q + 1'b1;
    end
    if (load) begin
      out_q <= bar;
    end
  end

  a_last_column: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.last) |-> out_q.column == COL_W'(COLUMNS - 2))
    else $error("last flag on wrong column");

  a_live_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> (state_q == B_EMIT) && (cnt_q == '0))
    else $error("bar sequence did not restart at live column");

endmodule
